// ----- hdl/tilt_posture_classifier_assert.svh -----
// Assertion macro used by the checker file.
`ifndef TILT_POSTURE_CLASSIFIER_ASSERT_SVH
`define TILT_POSTURE_CLASSIFIER_ASSERT_SVH

// Check an implication on every rising clock edge outside reset.
`define TPC_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- hdl/tpc_pkg.sv -----
`timescale 1ns / 1ps
package tpc_pkg;
	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 4;
	localparam int CORDIC_STAGES_DEF   = 16;
	localparam int TAB_FRAC            = 24;
	localparam int TAB_LEN             = 24;
	localparam int ZW                  = 36;
	localparam int XW                  = 36;

	typedef enum logic [2:0] {
		REG_STAND_LIMIT     = 3'd0,
		REG_SIT_WINDOW_LOW  = 3'd1,
		REG_SIT_WINDOW_HIGH = 3'd2,
		REG_LAY_PITCH_LIMIT = 3'd3,
		REG_FLAT_Z_LIMIT    = 3'd4,
		REG_POSTURE_LIMIT   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_UNKNOWN  = 2'd0,
		ACT_STANDING = 2'd1,
		ACT_SITTING  = 2'd2,
		ACT_LYING    = 2'd3
	} act_t;

	typedef struct packed {
		logic [11:0] stand_limit;
		logic [11:0] sit_window_low;
		logic [11:0] sit_window_high;
		logic [11:0] lay_pitch_limit;
		logic [15:0] flat_z_limit;
		logic [11:0] posture_limit;
	} cfg_t;

	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] t;
		begin
			unique case (i)
				0: t = 36'sd754974720;   1: t = 36'sd445687602;
				2: t = 36'sd235489088;   3: t = 36'sd119537938;
				4: t = 36'sd60000934;    5: t = 36'sd30029717;
				6: t = 36'sd15018523;    7: t = 36'sd7509720;
				8: t = 36'sd3754917;     9: t = 36'sd1877466;
				10: t = 36'sd938734;     11: t = 36'sd469367;
				12: t = 36'sd234684;     13: t = 36'sd117342;
				14: t = 36'sd58671;      15: t = 36'sd29335;
				16: t = 36'sd14668;      17: t = 36'sd7334;
				18: t = 36'sd3667;       19: t = 36'sd1833;
				20: t = 36'sd917;        21: t = 36'sd458;
				22: t = 36'sd229;        23: t = 36'sd115;
				default: t = '0;
			endcase
			return t;
		end
	endfunction
endpackage

// ----- hdl/tpc_if.sv -----
`timescale 1ns / 1ps
interface tpc_in_if #(parameter int SW = tpc_pkg::SAMPLE_BITS_DEF);
	logic valid;
	logic ready;
	logic signed [SW-1:0] upper_accel_x;
	logic signed [SW-1:0] upper_accel_y;
	logic signed [SW-1:0] upper_accel_z;
	logic signed [SW-1:0] lower_accel_x;
	logic signed [SW-1:0] lower_accel_y;
	logic signed [SW-1:0] lower_accel_z;
	modport source(output valid, upper_accel_x, upper_accel_y, upper_accel_z,
		lower_accel_x, lower_accel_y, lower_accel_z, input ready);
	modport sink(input valid, upper_accel_x, upper_accel_y, upper_accel_z,
		lower_accel_x, lower_accel_y, lower_accel_z, output ready);
endinterface

interface tpc_out_if;
	logic valid;
	logic ready;
	logic [1:0] activity;
	logic posture_alert;
	logic [11:0] angle_difference;
	logic signed [11:0] upper_pitch;
	logic signed [11:0] lower_pitch;
	logic signed [12:0] lower_roll;
	modport source(output valid, activity, posture_alert, angle_difference, upper_pitch,
		lower_pitch, lower_roll, input ready);
	modport sink(input valid, activity, posture_alert, angle_difference, upper_pitch,
		lower_pitch, lower_roll, output ready);
endinterface

interface tpc_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/tpc_isqrt_cell.sv -----
`timescale 1ns / 1ps
// One restoring square-root step: one result bit per cell.
module tpc_isqrt_cell #(
	parameter int NW = 64,
	parameter int K  = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] rem_i,
	input  logic [NW-1:0] res_i,
	output logic [NW-1:0] rem_q,
	output logic [NW-1:0] res_q
);
	logic [NW-1:0] bit_c;
	logic [NW-1:0] trial_c;
	always_comb begin
		bit_c   = NW'(1) << (2 * K);
		trial_c = res_i + bit_c;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_i >= trial_c) begin
				rem_q <= rem_i - trial_c;
				res_q <= (res_i >> 1) + bit_c;
			end else begin
				rem_q <= rem_i;
				res_q <= res_i >> 1;
			end
		end
	end
endmodule

// ----- hdl/tpc_cordic_cell.sv -----
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation.
module tpc_cordic_cell #(
	parameter int I = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [tpc_pkg::XW-1:0] x_i,
	input  logic signed [tpc_pkg::XW-1:0] y_i,
	input  logic signed [tpc_pkg::ZW-1:0] z_i,
	output logic signed [tpc_pkg::XW-1:0] x_q,
	output logic signed [tpc_pkg::XW-1:0] y_q,
	output logic signed [tpc_pkg::ZW-1:0] z_q
);
	logic signed [tpc_pkg::XW-1:0] dx_c, dy_c;
	logic signed [tpc_pkg::ZW-1:0] a_c;
	always_comb begin
		dx_c = y_i >>> I;
		dy_c = x_i >>> I;
		a_c  = tpc_pkg::atan_entry(I);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (y_i > 0) begin
				x_q <= x_i + dx_c;
				y_q <= y_i - dy_c;
				z_q <= z_i + a_c;
			end else begin
				x_q <= x_i - dx_c;
				y_q <= y_i + dy_c;
				z_q <= z_i - a_c;
			end
		end
	end
endmodule

// ----- hdl/tpc_atan2.sv -----
`timescale 1ns / 1ps
// Pipelined atan2: prerotation stage, a row of CORDIC cells, rounding stage.
module tpc_atan2 #(
	parameter int CORDIC_STAGES   = tpc_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_FRAC_BITS = tpc_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int LIMIT_DEG       = 90,
	parameter int OW              = 13
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [tpc_pkg::XW-1:0] y_i,
	input  logic signed [tpc_pkg::XW-1:0] x_i,
	output logic signed [OW-1:0]          ang_q
);
	localparam int NS  = (CORDIC_STAGES < tpc_pkg::TAB_LEN) ? CORDIC_STAGES
		: tpc_pkg::TAB_LEN;
	localparam int SH  = tpc_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [tpc_pkg::ZW-1:0] HALF = tpc_pkg::ZW'(1) <<< (SH - 1);
	localparam logic signed [tpc_pkg::ZW-1:0] LIM  =
		tpc_pkg::ZW'(LIMIT_DEG) <<< ANGLE_FRAC_BITS;
	localparam logic signed [tpc_pkg::ZW-1:0] D180 =
		tpc_pkg::ZW'(180) <<< tpc_pkg::TAB_FRAC;

	logic signed [tpc_pkg::XW-1:0] xs [NS+1];
	logic signed [tpc_pkg::XW-1:0] ys [NS+1];
	logic signed [tpc_pkg::ZW-1:0] zs [NS+1];
	logic zero_s [NS+1];
	logic signed [tpc_pkg::ZW-1:0] r_c;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_i == 0) && (y_i == 0);
			if (x_i < 0) begin
				xs[0] <= -x_i;
				ys[0] <= -y_i;
				zs[0] <= (y_i >= 0) ? D180 : -D180;
			end else begin
				xs[0] <= x_i;
				ys[0] <= y_i;
				zs[0] <= '0;
			end
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_cell
		tpc_cordic_cell #(.I(g)) u_cell (
			.clk(clk), .en(en), .x_i(xs[g]), .y_i(ys[g]), .z_i(zs[g]),
			.x_q(xs[g+1]), .y_q(ys[g+1]), .z_q(zs[g+1])
		);
		always_ff @(posedge clk) begin
			if (en) zero_s[g+1] <= zero_s[g];
		end
	end

	always_comb begin
		r_c = (zs[NS] + HALF) >>> SH;
		if (r_c > LIM) r_c = LIM;
		if (r_c < -LIM) r_c = -LIM;
		if (zero_s[NS]) r_c = '0;
	end

	always_ff @(posedge clk) begin
		if (en) ang_q <= OW'(r_c);
	end
endmodule

// ----- hdl/tilt_posture_classifier.sv -----
`timescale 1ns / 1ps
// Stages in order: input register, square-root cell row, CORDIC prerotation, CORDIC
// cell row, rounding register and the classify/output register.
// Throughput: one item per cycle; the whole pipe advances when the output
// register is empty or being taken, so a stalled output holds every stage.
// Reset: arst_n clears the valid bits and loads the register reset values.
module tilt_posture_classifier #(
	parameter int SAMPLE_BITS     = tpc_pkg::SAMPLE_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = tpc_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = tpc_pkg::CORDIC_STAGES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tpc_in_if.sink    in_ch,
	tpc_out_if.source out_ch,
	tpc_cfg_if.sink   cfg
);
	localparam int GB  = 31 - SAMPLE_BITS;
	localparam int NW  = 64;
	localparam int SQ  = 32;            // result bits of the square root
	localparam int NSC = (CORDIC_STAGES < tpc_pkg::TAB_LEN) ? CORDIC_STAGES
		: tpc_pkg::TAB_LEN;
	localparam int LAT = SQ + NSC + 3; // valid bit of the output register
	localparam int XW  = tpc_pkg::XW;

	tpc_pkg::cfg_t cfg_q;
	logic adv;
	logic [LAT:0] vld_s;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stand_limit     <= 12'd240;
			cfg_q.sit_window_low  <= 12'd800;
			cfg_q.sit_window_high <= 12'd2080;
			cfg_q.lay_pitch_limit <= 12'd960;
			cfg_q.flat_z_limit    <= 16'd4915;
			cfg_q.posture_limit   <= 12'd400;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tpc_pkg::REG_STAND_LIMIT:     cfg_q.stand_limit     <= cfg.data[11:0];
				tpc_pkg::REG_SIT_WINDOW_LOW:  cfg_q.sit_window_low  <= cfg.data[11:0];
				tpc_pkg::REG_SIT_WINDOW_HIGH: cfg_q.sit_window_high <= cfg.data[11:0];
				tpc_pkg::REG_LAY_PITCH_LIMIT: cfg_q.lay_pitch_limit <= cfg.data[11:0];
				tpc_pkg::REG_FLAT_Z_LIMIT:    cfg_q.flat_z_limit    <= cfg.data;
				tpc_pkg::REG_POSTURE_LIMIT:   cfg_q.posture_limit   <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	// Advance the whole pipe unless a finished result is stalled.
	assign adv         = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (adv) vld_s <= {vld_s[LAT-1:0], in_ch.valid};
	end

	// Stage 1: squares of y and z, scaled operands.
	logic [NW-1:0] usq_s1, lsq_s1;
	logic signed [XW-1:0] ux_s1, lx_s1, ly_s1, lz_s1;
	logic signed [2*SAMPLE_BITS-1:0] uyy_c, uzz_c, lyy_c, lzz_c;
	always_comb begin
		uyy_c = in_ch.upper_accel_y * in_ch.upper_accel_y;
		uzz_c = in_ch.upper_accel_z * in_ch.upper_accel_z;
		lyy_c = in_ch.lower_accel_y * in_ch.lower_accel_y;
		lzz_c = in_ch.lower_accel_z * in_ch.lower_accel_z;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			usq_s1 <= (NW'(unsigned'(uyy_c)) + NW'(unsigned'(uzz_c))) << (2 * GB);
			lsq_s1 <= (NW'(unsigned'(lyy_c)) + NW'(unsigned'(lzz_c))) << (2 * GB);
			ux_s1  <= -(XW'(in_ch.upper_accel_x) <<< GB);
			lx_s1  <= -(XW'(in_ch.lower_accel_x) <<< GB);
			ly_s1  <= XW'(in_ch.lower_accel_y) <<< GB;
			lz_s1  <= XW'(in_ch.lower_accel_z) <<< GB;
		end
	end

	// Square-root cell rows, numerators ride along.
	logic [NW-1:0] urem [SQ+1], ures [SQ+1], lrem [SQ+1], lres [SQ+1];
	logic signed [XW-1:0] unum [SQ+1], lnum [SQ+1], lyd [SQ+1], lzd [SQ+1];
	logic [15:0] lzabs [SQ+1];
	assign urem[0] = usq_s1;
	assign ures[0] = '0;
	assign lrem[0] = lsq_s1;
	assign lres[0] = '0;
	assign unum[0] = ux_s1;
	assign lnum[0] = lx_s1;
	assign lyd[0]  = ly_s1;
	assign lzd[0]  = lz_s1;
	assign lzabs[0] = 16'((lz_s1 < 0 ? -lz_s1 : lz_s1) >>> GB);
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		tpc_isqrt_cell #(.NW(NW), .K(SQ-1-k)) u_usq (
			.clk(clk), .en(adv), .rem_i(urem[k]), .res_i(ures[k]),
			.rem_q(urem[k+1]), .res_q(ures[k+1])
		);
		tpc_isqrt_cell #(.NW(NW), .K(SQ-1-k)) u_lsq (
			.clk(clk), .en(adv), .rem_i(lrem[k]), .res_i(lres[k]),
			.rem_q(lrem[k+1]), .res_q(lres[k+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				unum[k+1]  <= unum[k];
				lnum[k+1]  <= lnum[k];
				lyd[k+1]   <= lyd[k];
				lzd[k+1]   <= lzd[k];
				lzabs[k+1] <= lzabs[k];
			end
		end
	end

	// CORDIC pipes; the roll pipe lines up with the pitch pipes.
	logic signed [12:0] up_c, lp_c, lr_c;
	logic [15:0] lza [NSC+3];
	tpc_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.LIMIT_DEG(90), .OW(13)) u_up (
		.clk(clk), .en(adv), .y_i(unum[SQ]), .x_i(XW'(ures[SQ])), .ang_q(up_c));
	tpc_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.LIMIT_DEG(90), .OW(13)) u_lp (
		.clk(clk), .en(adv), .y_i(lnum[SQ]), .x_i(XW'(lres[SQ])), .ang_q(lp_c));
	tpc_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.LIMIT_DEG(180), .OW(13)) u_lr (
		.clk(clk), .en(adv), .y_i(lyd[SQ]), .x_i(lzd[SQ]), .ang_q(lr_c));
	assign lza[0] = lzabs[SQ];
	for (genvar m = 0; m < NSC + 2; m++) begin : g_zd
		always_ff @(posedge clk) begin
			if (adv) lza[m+1] <= lza[m];
		end
	end

	// Classify into the output register.
	logic [12:0] lpa_c, lra_c, diff_c;
	logic signed [13:0] d_c;
	logic [1:0] act_c;
	always_comb begin
		lpa_c  = lp_c[12] ? 13'(-lp_c) : 13'(lp_c);
		lra_c  = lr_c[12] ? 13'(-lr_c) : 13'(lr_c);
		d_c    = 14'(up_c) - 14'(lp_c);
		diff_c = 13'(d_c[13] ? -d_c : d_c);
		priority if (lpa_c < 13'(cfg_q.stand_limit) && lra_c < 13'(cfg_q.stand_limit))
			act_c = tpc_pkg::ACT_STANDING;
		else if ((lp_c > $signed({2'b0, cfg_q.sit_window_low})
				&& lp_c < $signed({2'b0, cfg_q.sit_window_high}))
				|| (lr_c > $signed({2'b0, cfg_q.sit_window_low})
				&& lr_c < $signed({2'b0, cfg_q.sit_window_high})))
			act_c = tpc_pkg::ACT_SITTING;
		else if (lpa_c > 13'(cfg_q.lay_pitch_limit) || lza[NSC+2] < cfg_q.flat_z_limit)
			act_c = tpc_pkg::ACT_LYING;
		else
			act_c = tpc_pkg::ACT_UNKNOWN;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.activity         <= act_c;
			out_ch.posture_alert    <= (act_c == tpc_pkg::ACT_STANDING
				|| act_c == tpc_pkg::ACT_SITTING) && diff_c > 13'(cfg_q.posture_limit);
			out_ch.angle_difference <= diff_c[11:0];
			out_ch.upper_pitch      <= up_c[11:0];
			out_ch.lower_pitch      <= lp_c[11:0];
			out_ch.lower_roll       <= lr_c;
		end
	end
	assign out_ch.valid = vld_s[LAT];
endmodule

// ----- hdl/tpc_checker.sv -----
`timescale 1ns / 1ps
`include "tilt_posture_classifier_assert.svh"
// Port-level checks on the classifier.
module tpc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] activity,
	input logic posture_alert,
	input logic cfg_ready
);
	`TPC_ASSERT_IMPL(a_ready_flow, clk, arst_n, !(out_valid && !out_ready) || !in_ready, "input taken while output stalled")
	`TPC_ASSERT_IMPL(a_bad_act, clk, arst_n, !(out_valid && posture_alert) || activity == tpc_pkg::ACT_STANDING || activity == tpc_pkg::ACT_SITTING, "posture alert outside standing or sitting")
	`TPC_ASSERT_IMPL(a_cfg_rdy, clk, arst_n, cfg_ready, "config port not ready")
endmodule

bind tilt_posture_classifier tpc_checker u_tpc_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .activity(out_ch.activity),
	.posture_alert(out_ch.posture_alert), .cfg_ready(cfg.ready)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Expected result of one sensor pair, at the block's field widths.
typedef struct packed {
	tpc_pkg::act_t activity;
	logic posture_alert;
	logic [11:0] angle_difference;
	logic [11:0] upper_pitch;
	logic [11:0] lower_pitch;
	logic [12:0] lower_roll;
} posture_t;

class posture_scoreboard;
	posture_t pending[$];
	tpc_pkg::cfg_t limits;
	int errors;

	function new();
		limits.stand_limit = 12'd240;
		limits.sit_window_low = 12'd800;
		limits.sit_window_high = 12'd2080;
		limits.lay_pitch_limit = 12'd960;
		limits.flat_z_limit = 16'd4915;
		limits.posture_limit = 12'd400;
		errors = 0;
	endfunction

	function void write_reg(tpc_pkg::reg_idx_t idx, logic [15:0] value);
		case (idx)
			tpc_pkg::REG_STAND_LIMIT: limits.stand_limit = value[11:0];
			tpc_pkg::REG_SIT_WINDOW_LOW: limits.sit_window_low = value[11:0];
			tpc_pkg::REG_SIT_WINDOW_HIGH: limits.sit_window_high = value[11:0];
			tpc_pkg::REG_LAY_PITCH_LIMIT: limits.lay_pitch_limit = value[11:0];
			tpc_pkg::REG_FLAT_Z_LIMIT: limits.flat_z_limit = value;
			tpc_pkg::REG_POSTURE_LIMIT: limits.posture_limit = value[11:0];
			default: ;
		endcase
	endfunction

	function longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n = n - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	function longint vector_angle(longint y, longint x, longint limit_deg);
		longint acc, dx, dy, r, lim;
		acc = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			acc = (y >= 0) ? (longint'(180) <<< 24) : -(longint'(180) <<< 24);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx; y = y - dy; acc = acc + longint'(tpc_pkg::atan_entry(i));
			end else begin
				x = x - dx; y = y + dy; acc = acc - longint'(tpc_pkg::atan_entry(i));
			end
		end
		r = (acc + (longint'(1) <<< 19)) >>> 20;
		lim = limit_deg <<< 4;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function longint pitch(longint x, longint y, longint z);
		longint unsigned sq;
		longint den;
		sq = longint'(y * y) + longint'(z * z);
		den = longint'(int_sqrt(sq << 30));
		return vector_angle(-x * 32768, den, 90);
	endfunction

	function longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Predict the result of one accepted sensor pair and queue it.
	function void note_sample(logic signed [15:0] ux, logic signed [15:0] uy,
		logic signed [15:0] uz, logic signed [15:0] lx, logic signed [15:0] ly,
		logic signed [15:0] lz);
		longint up, lp, lr, lo, hi, diff;
		posture_t p;
		up = pitch(ux, uy, uz);
		lp = pitch(lx, ly, lz);
		lr = vector_angle(longint'(ly) * 32768, longint'(lz) * 32768, 180);
		lo = limits.sit_window_low;
		hi = limits.sit_window_high;
		diff = mag(up - lp);
		if (mag(lp) < limits.stand_limit && mag(lr) < limits.stand_limit)
			p.activity = tpc_pkg::ACT_STANDING;
		else if ((lp > lo && lp < hi) || (lr > lo && lr < hi))
			p.activity = tpc_pkg::ACT_SITTING;
		else if (mag(lp) > limits.lay_pitch_limit || mag(lz) < limits.flat_z_limit)
			p.activity = tpc_pkg::ACT_LYING;
		else
			p.activity = tpc_pkg::ACT_UNKNOWN;
		p.posture_alert = (p.activity == tpc_pkg::ACT_STANDING ||
			p.activity == tpc_pkg::ACT_SITTING) && diff > limits.posture_limit;
		p.angle_difference = diff[11:0];
		p.upper_pitch = up[11:0];
		p.lower_pitch = lp[11:0];
		p.lower_roll = lr[12:0];
		pending.push_back(p);
	endfunction

	task report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task check_result(posture_t got);
		posture_t want;
		if (pending.size() == 0) begin
			report("result with nothing pending", 0, 0);
			return;
		end
		want = pending.pop_front();
		if (got.activity != want.activity)
			report("activity", got.activity, want.activity);
		if (got.posture_alert != want.posture_alert)
			report("posture_alert", got.posture_alert, want.posture_alert);
		if (got.angle_difference != want.angle_difference)
			report("angle_difference", got.angle_difference, want.angle_difference);
		if (got.upper_pitch != want.upper_pitch)
			report("upper_pitch", got.upper_pitch, want.upper_pitch);
		if (got.lower_pitch != want.lower_pitch)
			report("lower_pitch", got.lower_pitch, want.lower_pitch);
		if (got.lower_roll != want.lower_roll)
			report("lower_roll", got.lower_roll, want.lower_roll);
	endtask
endclass

module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	tpc_in_if in_ch();
	tpc_out_if out_ch();
	tpc_cfg_if cfg();

	posture_scoreboard sb = new();
	int max_gap = 9;       // upper bound of the idle draw on both sides
	bit hold_output = 0;   // request for one long receiver hold-off

	tilt_posture_classifier dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always #5 clk = ~clk;

	// Note accepted items and register writes, check results, all at the rising edge.
	always @(posedge clk) begin
		posture_t got;
		if (in_ch.valid && in_ch.ready)
			sb.note_sample(in_ch.upper_accel_x, in_ch.upper_accel_y, in_ch.upper_accel_z,
				in_ch.lower_accel_x, in_ch.lower_accel_y, in_ch.lower_accel_z);
		if (cfg.valid && cfg.ready)
			sb.write_reg(tpc_pkg::reg_idx_t'(cfg.index), cfg.data);
		if (out_ch.valid && out_ch.ready) begin
			got.activity = tpc_pkg::act_t'(out_ch.activity);
			got.posture_alert = out_ch.posture_alert;
			got.angle_difference = out_ch.angle_difference;
			got.upper_pitch = out_ch.upper_pitch;
			got.lower_pitch = out_ch.lower_pitch;
			got.lower_roll = out_ch.lower_roll;
			sb.check_result(got);
		end
	end

	// Receiver: draw a wait per item; on request hold off for a long stretch.
	initial begin
		int n;
		out_ch.ready = 1'b0;
		forever begin
			n = $urandom_range(0, max_gap);
			if (hold_output) begin
				hold_output = 0;
				n = 300;
			end
			if (n > 0) begin
				@(negedge clk) out_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk) out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	// Offer one sensor pair after a random gap; hold it until taken.
	task send_pair(logic [15:0] ux, logic [15:0] uy, logic [15:0] uz,
		logic [15:0] lx, logic [15:0] ly, logic [15:0] lz);
		int n;
		n = $urandom_range(0, max_gap);
		if (n > 0) begin
			@(negedge clk) in_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.upper_accel_x <= ux; in_ch.upper_accel_y <= uy; in_ch.upper_accel_z <= uz;
		in_ch.lower_accel_x <= lx; in_ch.lower_accel_y <= ly; in_ch.lower_accel_z <= lz;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
	endtask

	task stop_input();
		@(negedge clk) in_ch.valid <= 1'b0;
	endtask

	task write_limit(tpc_pkg::reg_idx_t idx, logic [15:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!(cfg.valid && cfg.ready));
		@(negedge clk) cfg.valid <= 1'b0;
	endtask

	// Let every pending result drain before touching the registers.
	task drain();
		stop_input();
		wait (sb.pending.size() == 0);
		repeat (50) @(posedge clk);
	endtask

	task load_limits(int s, int lo, int hi, int lay, int flat, int post);
		write_limit(tpc_pkg::REG_STAND_LIMIT, 16'(s));
		write_limit(tpc_pkg::REG_SIT_WINDOW_LOW, 16'(lo));
		write_limit(tpc_pkg::REG_SIT_WINDOW_HIGH, 16'(hi));
		write_limit(tpc_pkg::REG_LAY_PITCH_LIMIT, 16'(lay));
		write_limit(tpc_pkg::REG_FLAT_Z_LIMIT, 16'(flat));
		write_limit(tpc_pkg::REG_POSTURE_LIMIT, 16'(post));
	endtask

	// One axis near +-1 g or zero with noise, so angles land near the class limits.
	function logic [15:0] near_g();
		int base, noise;
		case ($urandom_range(0, 2))
			0: base = 16384;
			1: base = -16384;
			default: base = 0;
		endcase
		noise = $urandom_range(0, 12000) - 6000;
		return 16'(base + noise);
	endfunction

	task random_pairs(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_pair(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			else
				send_pair(near_g(), near_g(), near_g(), near_g(), near_g(), near_g());
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.upper_accel_x = '0; in_ch.upper_accel_y = '0; in_ch.upper_accel_z = '0;
		in_ch.lower_accel_x = '0; in_ch.lower_accel_y = '0; in_ch.lower_accel_z = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: zero vectors, full-scale corners, upright, flat, roll at 180.
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_pair(16'h8000, 0, 0, 16'h7fff, 0, 0);
		send_pair(16'h7fff, 0, 0, 16'h8000, 0, 0);
		send_pair(0, 0, 16384, 0, 0, 16384);
		send_pair(0, 0, 16384, 0, 0, -16384);
		send_pair(0, 0, -16384, 0, 16'h8000, 0);
		send_pair(0, 0, 16384, 0, 16'h7fff, 0);
		send_pair(0, 16384, 0, -14189, 0, 8192);
		send_pair(-8192, 0, 14189, 0, 14189, 8192);
		send_pair(-14189, 0, 8192, 0, 0, 16384);
		send_pair(0, 0, 16384, 16384, 0, 100);
		send_pair(0, 0, 16384, 1000, 1000, 4914);
		send_pair(0, 0, 16384, 1000, 1000, 4915);
		send_pair(0, 0, 16384, 0, 0, 16'h8000);
		send_pair(1, 0, 0, 0, 1, 16'hffff);
		send_pair(16'hffff, 1, 16'hffff, 0, 16'hffff, 16'hffff);
		random_pairs(100);
		drain();

		// Bottom of every range; the unused indexes must leave the limits alone.
		load_limits(0, 0, 0, 0, 0, 0);
		write_limit(tpc_pkg::reg_idx_t'(3'd6), 16'hffff);
		write_limit(tpc_pkg::reg_idx_t'(3'd7), 16'h1234);
		random_pairs(100);
		drain();

		// Top of every range, with the sender never idle.
		load_limits(2880, 2880, 2880, 2880, 32768, 2880);
		max_gap = 0;
		random_pairs(100);
		drain();

		// Upper bits beyond each 12-bit field get dropped by the block; flat-z takes all 16 bits.
		max_gap = 9;
		load_limits(16'hffff, 16'hf320, 16'hf820, 16'hf3c0, 16'hffff, 16'hf190);
		random_pairs(100);
		drain();

		// Back to typical limits; force a long receiver hold-off so the pipe fills.
		load_limits(240, 800, 2080, 960, 4915, 400);
		hold_output = 1;
		max_gap = 0;
		random_pairs(120);
		max_gap = 9;
		drain();

		load_limits($urandom_range(0, 2880), $urandom_range(0, 1400),
			$urandom_range(1400, 2880), $urandom_range(0, 2880),
			$urandom_range(0, 32768), $urandom_range(0, 2880));
		random_pairs(130);
		drain();

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tpc_pkg.sv
hdl/tpc_if.sv
hdl/tpc_isqrt_cell.sv
hdl/tpc_cordic_cell.sv
hdl/tpc_atan2.sv
hdl/tilt_posture_classifier.sv
hdl/tpc_checker.sv
verif/testbench.sv
